FILE: rtl/core/chewr_pkg.sv
// Package: shared types and constants of the calorimeter hit energy reweighting core.
`timescale 1ns / 1ps
package chewr_pkg;

	localparam int DENSITY_BINS = 10;
	localparam int DIV_STEPS    = 64;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

	localparam logic [31:0] LOG2E_Q   = 32'd94548;
	localparam logic [31:0] VOL_SCALE = 32'd4096000000;
	localparam logic [31:0] EXP_C2    = 32'd5119;
	localparam logic [31:0] EXP_C1    = 32'd14824;
	localparam logic [31:0] EXP_C0    = 32'd45593;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	localparam logic [31:0] BIN_LOW [DENSITY_BINS] = '{
		32'd19661, 32'd131072, 32'd360448, 32'd524288, 32'd655360,
		32'd917504, 32'd1114112, 32'd1376256, 32'd1638400, 32'd1966080};
	localparam logic [31:0] BIN_MID [DENSITY_BINS] = '{
		32'd75366, 32'd245760, 32'd442368, 32'd589824, 32'd786432,
		32'd1015808, 32'd1245184, 32'd1507328, 32'd1802240, 32'd2621440};

	// Configuration register indexes
	localparam logic [2:0] CFG_P10_P11  = 3'd0;
	localparam logic [2:0] CFG_P12_P20  = 3'd1;
	localparam logic [2:0] CFG_P21_P22  = 3'd2;
	localparam logic [2:0] CFG_P30_P31  = 3'd3;
	localparam logic [2:0] CFG_P32_TRUE = 3'd4;
	localparam logic [2:0] CFG_MIN_HAD  = 3'd5;
	localparam logic [2:0] CFG_CHEAT    = 3'd6;

	// Hit types
	localparam logic [1:0] HIT_ECAL = 2'd0;
	localparam logic [1:0] HIT_HCAL = 2'd1;

	// Cluster classes
	localparam logic [2:0] CLS_EMPTY = 3'd0;
	localparam logic [2:0] CLS_LOW   = 3'd1;
	localparam logic [2:0] CLS_ECAL  = 3'd2;
	localparam logic [2:0] CLS_HCAL  = 3'd3;
	localparam logic [2:0] CLS_SPLIT = 3'd4;

	typedef struct packed {
		logic signed [31:0] p10;
		logic signed [31:0] p11;
		logic signed [31:0] p12;
		logic signed [31:0] p20;
		logic signed [31:0] p21;
		logic signed [31:0] p22;
		logic signed [31:0] p30;
		logic signed [31:0] p31;
		logic signed [31:0] p32;
		logic [31:0]        true_energy;
		logic [31:0]        min_had;
		logic               cheat;
	} cfg_t;

	typedef struct packed {
		logic        hit_valid;
		logic [1:0]  hit_type;
		logic [31:0] hit_energy;
		logic [31:0] mip_energy;
		logic [15:0] cell_size_a;
		logic [15:0] cell_size_b;
		logic [15:0] cell_depth;
		logic [31:0] cluster_energy;
		logic        last_hit;
	} item_t;

	typedef struct packed {
		logic [2:0]  cluster_class;
		logic        energy_written;
		logic [31:0] corrected_energy;
	} res_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_P_MUL0, ST_P_TAKE0, ST_P_MUL1, ST_P_TAKE1, ST_P_MUL2, ST_P_TAKE2,
		ST_F_MUL, ST_F_TAKE, ST_F_DEN, ST_F_DIV, ST_F_WAIT,
		ST_X_MUL0, ST_X_TAKE0, ST_X_MUL1, ST_X_TAKE1, ST_X_MUL2, ST_X_TAKE2,
		ST_X_MUL3, ST_X_TAKE3,
		ST_D_BIN, ST_D_WAIT0, ST_D_MUL0, ST_D_TAKE0, ST_D_MUL1, ST_D_TAKE1,
		ST_D_MUL2, ST_D_TAKE2, ST_D_MUL3, ST_D_DIV, ST_D_WAIT1,
		ST_W_MUL0, ST_W_TAKE0, ST_W_MUL1, ST_W_TAKE1, ST_W_MUL2, ST_W_ACC,
		ST_FIN
	} st_t;

endpackage

FILE: rtl/core/chewr_mul.sv
// Module: shared registered 32x32 magnitude multiplier with sign tag.
`timescale 1ns / 1ps
module chewr_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic        neg,
	output logic [63:0] prod_q,
	output logic        neg_q
);

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
		neg_q  <= neg;
	end

endmodule

FILE: rtl/core/chewr_div.sv
// Module: radix-2 restoring divider, 64-bit dividend by 48-bit divisor.
`timescale 1ns / 1ps
module chewr_div
	import chewr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [47:0] den,
	output logic        busy,
	output logic [63:0] quo
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [47:0]          rem_q;
	logic [63:0]          quo_q;
	logic [47:0]          den_q;
	logic [48:0]          trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[63]};
	assign ge    = trial >= {1'b0, den_q};
	assign busy  = busy_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 48'(trial - {1'b0, den_q}) : trial[47:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end

endmodule

FILE: rtl/core/chewr_seq.sv
// Module: sequencer and datapath registers around the shared multiplier and divider.
`timescale 1ns / 1ps
module chewr_seq
	import chewr_pkg::*;
#(
	parameter int MAX_HITS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        res_valid,
	input  logic        out_free,
	output res_t        res
);

	localparam int CAP   = (MAX_HITS < 8191) ? MAX_HITS : 8191;
	localparam int CNT_W = $clog2(CAP + 1);

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		if (v > 51'sd2147483647)
			sat32 = S32_MAX;
		else if (v < -51'sd2147483648)
			sat32 = S32_MIN;
		else
			sat32 = v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		if (v > 50'sd140737488355327)
			sat48 = 48'sh7FFFFFFFFFFF;
		else if (v < -50'sd140737488355328)
			sat48 = 48'sh800000000000;
		else
			sat48 = v[47:0];
	endfunction

	st_t state_q, state_d, ret_q;
	logic                sel_q;
	logic                first_q;
	logic signed [31:0]  amp_q, slope_q, offset_q;
	logic signed [47:0]  wsum_q, ssum_q;
	logic [CNT_W-1:0]    ecnt_q, hcnt_q;

	item_t               item_q;
	logic signed [31:0]  opa_q, y_q, ex_q;
	logic signed [50:0]  acc_q;
	logic [16:0]         et_q;
	logic signed [32:0]  d_q;
	logic [31:0]         mid_q, ratio_q, tr_q;
	logic [47:0]         vol_q;
	logic [30:0]         rho_q;

	logic [31:0]         mul_a, mul_b;
	logic                mul_neg;
	logic [63:0]         prod;
	logic                prod_neg;
	logic signed [48:0]  qm;

	logic                div_start, div_busy;
	logic [63:0]         div_num, div_quo;
	logic [47:0]         div_den;

	logic [31:0]         e_sel;
	logic signed [31:0]  c0, c1, c2;
	logic [31:0]         mid_c;
	logic [32:0]         d_mag;
	logic signed [31:0]  offset_div;
	logic signed [31:0]  exp_res;
	logic [17:0]         exp_m;
	logic signed [15:0]  exp_k;
	logic [16:0]         exp_nk;
	logic [31:0]         exp_up;
	logic signed [47:0]  fin_sum;
	res_t                fin_res;

	chewr_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.neg    (mul_neg),
		.prod_q (prod),
		.neg_q  (prod_neg)
	);

	chewr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	// signed 49-bit product in Q32.16 (16 fraction bits) from the registered magnitude product
	assign qm = prod_neg ? -$signed({1'b0, prod[63:16]}) : $signed({1'b0, prod[63:16]});

	assign e_sel = cfg.cheat ? cfg.true_energy : item_q.cluster_energy;
	assign c0    = sel_q ? cfg.p20 : cfg.p10;
	assign c1    = sel_q ? cfg.p21 : cfg.p11;
	assign c2    = sel_q ? cfg.p22 : cfg.p12;
	assign d_mag = d_q[32] ? 33'(-d_q) : 33'(d_q);

	// density bin midpoint, zero below the lowest bound
	always_comb begin
		mid_c = '0;
		for (int i = 0; i < DENSITY_BINS - 1; i++) begin
			if (item_q.mip_energy >= BIN_LOW[i] && item_q.mip_energy < BIN_LOW[i + 1])
				mid_c = BIN_MID[i];
		end
		if (item_q.mip_energy >= BIN_LOW[DENSITY_BINS - 1])
			mid_c = BIN_MID[DENSITY_BINS - 1];
	end

	// 2^f mantissa shifted by the integer part of the exponent
	always_comb begin
		exp_m  = 18'd65536 + prod[33:16];
		exp_k  = y_q[31:16];
		exp_nk = 17'(-$signed({exp_k[15], exp_k}));
		exp_up = 32'(exp_m) << exp_k[3:0];
		if (!exp_k[15]) begin
			if (exp_k >= 16'sd15 || exp_up[31])
				exp_res = S32_MAX;
			else
				exp_res = $signed(exp_up);
		end else if (exp_nk >= 17'd32) begin
			exp_res = '0;
		end else begin
			exp_res = $signed(32'(exp_m) >> exp_nk[4:0]);
		end
	end

	// quotient of p30 over (p31 + exp), signed and saturated
	always_comb begin
		if (cfg.p30[31] ^ d_q[32]) begin
			if (div_quo >= 64'h80000000)
				offset_div = S32_MIN;
			else
				offset_div = 32'(-$signed(div_quo[32:0]));
		end else if (div_quo > 64'h7FFFFFFF) begin
			offset_div = S32_MAX;
		end else begin
			offset_div = $signed(div_quo[31:0]);
		end
	end

	// cluster result
	always_comb begin
		fin_res = '0;
		fin_sum = '0;
		if (first_q) begin
			fin_res.cluster_class  = CLS_EMPTY;
			fin_res.energy_written = 1'b1;
		end else if (item_q.cluster_energy < cfg.min_had) begin
			fin_res.cluster_class = CLS_LOW;
		end else if (ecnt_q != '0 && hcnt_q == '0) begin
			fin_res.cluster_class = CLS_ECAL;
		end else if (hcnt_q != '0 && ecnt_q == '0) begin
			fin_res.cluster_class  = CLS_HCAL;
			fin_res.energy_written = 1'b1;
			fin_sum                = wsum_q;
		end else begin
			fin_res.cluster_class  = CLS_SPLIT;
			fin_res.energy_written = 1'b1;
			fin_sum                = ssum_q;
		end
		if (fin_sum > 48'sd0)
			fin_res.corrected_energy = (fin_sum[47:32] != '0) ? 32'hFFFFFFFF : fin_sum[31:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_item.hit_valid)
						state_d = first_q ? ST_P_MUL0 : ST_D_BIN;
					else if (in_item.last_hit)
						state_d = ST_FIN;
				end
			end
			ST_P_MUL0:  state_d = ST_P_TAKE0;
			ST_P_TAKE0: state_d = ST_P_MUL1;
			ST_P_MUL1:  state_d = ST_P_TAKE1;
			ST_P_TAKE1: state_d = ST_P_MUL2;
			ST_P_MUL2:  state_d = ST_P_TAKE2;
			ST_P_TAKE2: state_d = sel_q ? ST_F_MUL : ST_P_MUL0;
			ST_F_MUL:   state_d = ST_F_TAKE;
			ST_F_TAKE:  state_d = ST_X_MUL0;
			ST_F_DEN:   state_d = ST_F_DIV;
			ST_F_DIV:   state_d = (d_q == '0) ? ST_D_BIN : ST_F_WAIT;
			ST_F_WAIT:  state_d = div_busy ? ST_F_WAIT : ST_D_BIN;
			ST_X_MUL0:  state_d = ST_X_TAKE0;
			ST_X_TAKE0: state_d = ST_X_MUL1;
			ST_X_MUL1:  state_d = ST_X_TAKE1;
			ST_X_TAKE1: state_d = ST_X_MUL2;
			ST_X_MUL2:  state_d = ST_X_TAKE2;
			ST_X_TAKE2: state_d = ST_X_MUL3;
			ST_X_MUL3:  state_d = ST_X_TAKE3;
			ST_X_TAKE3: state_d = ret_q;
			ST_D_BIN:   state_d = (mid_c == '0) ? ST_W_MUL0 : ST_D_WAIT0;
			ST_D_WAIT0: state_d = div_busy ? ST_D_WAIT0 : ST_D_MUL0;
			ST_D_MUL0:  state_d = ST_D_TAKE0;
			ST_D_TAKE0: state_d = ST_D_MUL1;
			ST_D_MUL1:  state_d = ST_D_TAKE1;
			ST_D_TAKE1: state_d = ST_D_MUL2;
			ST_D_MUL2:  state_d = ST_D_TAKE2;
			ST_D_TAKE2: state_d = ST_D_MUL3;
			ST_D_MUL3:  state_d = ST_D_DIV;
			ST_D_DIV:   state_d = (vol_q == '0) ? ST_W_MUL0 : ST_D_WAIT1;
			ST_D_WAIT1: state_d = div_busy ? ST_D_WAIT1 : ST_W_MUL0;
			ST_W_MUL0:  state_d = ST_W_TAKE0;
			ST_W_TAKE0: state_d = ST_X_MUL0;
			ST_W_MUL1:  state_d = ST_W_TAKE1;
			ST_W_TAKE1: state_d = ST_W_MUL2;
			ST_W_MUL2:  state_d = ST_W_ACC;
			ST_W_ACC:   state_d = item_q.last_hit ? ST_FIN : ST_IDLE;
			ST_FIN:     state_d = out_free ? ST_IDLE : ST_FIN;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake, multiplier and divider operands
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		res       = fin_res;
		mul_a     = '0;
		mul_b     = '0;
		mul_neg   = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_P_MUL0: begin
				mul_a = mag32(c2); mul_b = e_sel; mul_neg = c2[31];
			end
			ST_P_MUL1: begin
				mul_a = mag32(opa_q); mul_b = e_sel; mul_neg = opa_q[31];
			end
			ST_P_MUL2: begin
				mul_a = mag32(c1); mul_b = e_sel; mul_neg = c1[31];
			end
			ST_F_MUL: begin
				mul_a = mag32(cfg.p32); mul_b = e_sel; mul_neg = cfg.p32[31];
			end
			ST_F_DIV: begin
				div_start = (d_q != '0);
				div_num   = {16'd0, mag32(cfg.p30), 16'd0};
				div_den   = 48'(d_mag);
			end
			ST_X_MUL0: begin
				mul_a = mag32(opa_q); mul_b = LOG2E_Q; mul_neg = opa_q[31];
			end
			ST_X_MUL1: begin
				mul_a = EXP_C2; mul_b = {16'd0, y_q[15:0]};
			end
			ST_X_MUL2: begin
				mul_a = EXP_C1 + 32'(et_q); mul_b = {16'd0, y_q[15:0]};
			end
			ST_X_MUL3: begin
				mul_a = EXP_C0 + 32'(et_q); mul_b = {16'd0, y_q[15:0]};
			end
			ST_D_BIN: begin
				div_start = (mid_c != '0);
				div_num   = {16'd0, item_q.hit_energy, 16'd0};
				div_den   = {16'd0, item_q.mip_energy};
			end
			ST_D_MUL0: begin
				mul_a = mid_q; mul_b = ratio_q;
			end
			ST_D_MUL1: begin
				mul_a = 32'(item_q.cell_size_a); mul_b = 32'(item_q.cell_size_b);
			end
			ST_D_MUL2: begin
				mul_a = vol_q[31:0]; mul_b = 32'(item_q.cell_depth);
			end
			ST_D_MUL3: begin
				mul_a = tr_q; mul_b = VOL_SCALE;
			end
			ST_D_DIV: begin
				div_start = (vol_q != '0);
				div_num   = prod;
				div_den   = vol_q;
			end
			ST_W_MUL0: begin
				mul_a = mag32(slope_q); mul_b = {1'b0, rho_q}; mul_neg = slope_q[31];
			end
			ST_W_MUL1: begin
				mul_a = mag32(amp_q); mul_b = ex_q; mul_neg = amp_q[31];
			end
			ST_W_MUL2: begin
				mul_a = item_q.hit_energy; mul_b = mag32(opa_q); mul_neg = opa_q[31];
			end
			ST_FIN:    res_valid = 1'b1;
			default: begin
			end
		endcase
	end

	// control and cluster state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			sel_q    <= 1'b0;
			first_q  <= 1'b1;
			amp_q    <= '0;
			slope_q  <= '0;
			offset_q <= '0;
			wsum_q   <= '0;
			ssum_q   <= '0;
			ecnt_q   <= '0;
			hcnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE:   sel_q <= 1'b0;
				ST_P_TAKE2: begin
					if (sel_q)
						slope_q <= sat32(acc_q + 51'(qm));
					else
						amp_q <= sat32(acc_q + 51'(qm));
					sel_q <= 1'b1;
				end
				ST_F_TAKE: ret_q <= ST_F_DEN;
				ST_F_DIV: begin
					if (d_q == '0) begin
						offset_q <= cfg.p30[31] ? S32_MIN :
							((cfg.p30 != '0) ? S32_MAX : 32'sd0);
						first_q  <= 1'b0;
					end
				end
				ST_F_WAIT: begin
					if (!div_busy) begin
						offset_q <= offset_div;
						first_q  <= 1'b0;
					end
				end
				ST_W_TAKE0: ret_q <= ST_W_MUL1;
				ST_W_ACC: begin
					wsum_q <= sat48(50'(wsum_q) + 50'(qm));
					if (item_q.hit_type == HIT_HCAL) begin
						ssum_q <= sat48(50'(ssum_q) + 50'(qm));
						if (hcnt_q < CNT_W'(CAP))
							hcnt_q <= hcnt_q + 1'b1;
					end else begin
						ssum_q <= sat48(50'(ssum_q) + $signed({18'd0, item_q.hit_energy}));
						if (item_q.hit_type == HIT_ECAL && ecnt_q < CNT_W'(CAP))
							ecnt_q <= ecnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						first_q  <= 1'b1;
						amp_q    <= '0;
						slope_q  <= '0;
						offset_q <= '0;
						wsum_q   <= '0;
						ssum_q   <= '0;
						ecnt_q   <= '0;
						hcnt_q   <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// operand and intermediate registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:    if (in_valid) item_q <= in_item;
			ST_P_TAKE0: opa_q <= sat32(51'(qm));
			ST_P_TAKE1: acc_q <= 51'(c0) + 51'(qm);
			ST_F_TAKE:  opa_q <= sat32(51'(qm));
			ST_F_DEN:   d_q <= 33'(cfg.p31) + 33'(ex_q);
			ST_X_TAKE0: y_q <= sat32(51'(qm));
			ST_X_TAKE1: et_q <= prod[32:16];
			ST_X_TAKE2: et_q <= prod[32:16];
			ST_X_TAKE3: ex_q <= exp_res;
			ST_D_BIN: begin
				mid_q <= mid_c;
				if (mid_c == '0)
					rho_q <= '0;
			end
			ST_D_WAIT0: ratio_q <= (div_quo[63:32] != '0) ? 32'hFFFFFFFF : div_quo[31:0];
			ST_D_TAKE0: tr_q <= (prod[63:48] != '0) ? 32'hFFFFFFFF : prod[47:16];
			ST_D_TAKE1: vol_q <= {16'd0, prod[31:0]};
			ST_D_TAKE2: vol_q <= prod[47:0];
			ST_D_DIV:   if (vol_q == '0) rho_q <= '1;
			ST_D_WAIT1: rho_q <= (div_quo[63:31] != '0) ? 31'h7FFFFFFF : div_quo[30:0];
			ST_W_TAKE0: opa_q <= sat32(51'(qm));
			ST_W_TAKE1: opa_q <= sat32(51'(qm) + 51'(offset_q));
			default: begin
			end
		endcase
	end

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_clear_when_first: assert property (@(posedge clk) disable iff (!arst_n)
		first_q |-> (wsum_q == '0 && ssum_q == '0 && ecnt_q == '0 && hcnt_q == '0))
		else $error("cluster sums not clear before first hit");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(ecnt_q <= CNT_W'(CAP)) && (hcnt_q <= CNT_W'(CAP)))
		else $error("hit count beyond cap");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (state_q == ST_IDLE && first_q))
		else $error("cluster not closed after result transfer");

endmodule

FILE: rtl/core/calorimeter_hit_energy_reweighting_core.sv
// Top level: calorimeter hit energy reweighting core with stream ports and config registers.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata, tuser, tlast (one hit)
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata, tuser (one cluster result)
//  cfg       in         cfg_we (no wait)               cfg_addr, cfg_wdata
//
//  A valid hit holds ready low until its weight is added; the density steps are cut
//  short when the MIP energy is below the lowest bound or the cell volume is zero. The
//  first valid hit of a cluster first latches p1, p2 and p3. Each weight takes up to
//  two 64-step radix-2 divisions (energy ratio and volume scaling), and all products
//  share the single multiplier. An item with no hit goes straight back to idle, or
//  via ST_FIN when it closes the cluster, where a closing hit also hands its result over.
//  Reset (arst_n low) at once clears sums, counts, terms, config; min_had goes to 655360.
//  A result waits in the output register while the next hit is already taken.
//
module calorimeter_hit_energy_reweighting_core
	import chewr_pkg::*;
#(
	parameter int MAX_HITS = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] hit_energy, [63:32] mip_energy, [79:64] cell_size_a,
	// [95:80] cell_size_b, [111:96] cell_depth, [143:112] cluster_energy
	input  logic [143:0] s_axis_tdata,
	// [0] hit_valid, [2:1] hit_type
	input  logic [2:0]   s_axis_tuser,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] corrected_energy
	output logic [31:0]  m_axis_tdata,
	// [2:0] cluster_class, [3] energy_written
	output logic [3:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [63:0]  cfg_wdata
);

	logic [63:0] p10_p11_q, p12_p20_q, p21_p22_q, p30_p31_q, p32_true_q;
	logic [31:0] min_had_q;
	logic        cheat_q;
	cfg_t        cfg;
	item_t       in_item;
	res_t        res, out_res_q;
	logic        res_valid;
	logic        out_valid_q;
	logic        out_free;

	// register file: write only, ignore indexes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p10_p11_q  <= '0;
			p12_p20_q  <= '0;
			p21_p22_q  <= '0;
			p30_p31_q  <= '0;
			p32_true_q <= '0;
			min_had_q  <= 32'd655360;
			cheat_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_P10_P11:  p10_p11_q  <= cfg_wdata;
				CFG_P12_P20:  p12_p20_q  <= cfg_wdata;
				CFG_P21_P22:  p21_p22_q  <= cfg_wdata;
				CFG_P30_P31:  p30_p31_q  <= cfg_wdata;
				CFG_P32_TRUE: p32_true_q <= cfg_wdata;
				CFG_MIN_HAD:  min_had_q  <= cfg_wdata[31:0];
				CFG_CHEAT:    cheat_q    <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// split each 64-bit register into its two halves, first named in the low half
	always_comb begin
		cfg.p10         = p10_p11_q[31:0];
		cfg.p11         = p10_p11_q[63:32];
		cfg.p12         = p12_p20_q[31:0];
		cfg.p20         = p12_p20_q[63:32];
		cfg.p21         = p21_p22_q[31:0];
		cfg.p22         = p21_p22_q[63:32];
		cfg.p30         = p30_p31_q[31:0];
		cfg.p31         = p30_p31_q[63:32];
		cfg.p32         = p32_true_q[31:0];
		cfg.true_energy = p32_true_q[63:32];
		cfg.min_had     = min_had_q;
		cfg.cheat       = cheat_q;
	end

	// unpack the input transfer
	always_comb begin
		in_item.hit_valid      = s_axis_tuser[0];
		in_item.hit_type       = s_axis_tuser[2:1];
		in_item.hit_energy     = s_axis_tdata[31:0];
		in_item.mip_energy     = s_axis_tdata[63:32];
		in_item.cell_size_a    = s_axis_tdata[79:64];
		in_item.cell_size_b    = s_axis_tdata[95:80];
		in_item.cell_depth     = s_axis_tdata[111:96];
		in_item.cluster_energy = s_axis_tdata[143:112];
		in_item.last_hit       = s_axis_tlast;
	end

	chewr_seq #(
		.MAX_HITS (MAX_HITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.out_free  (out_free),
		.res       (res)
	);

	// output register: load when empty or draining this cycle
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && out_free)
			out_res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_res_q.corrected_energy;
	assign m_axis_tuser  = {out_res_q.energy_written, out_res_q.cluster_class};

endmodule
